// ===== design/utmr_pkg.sv =====
// ----------------------------------------------------------------------------
// utmr_pkg
// Shared types, constants and the reverse MacRoman lookup for the
// UTF-8 to MacRoman transcoder.
// ----------------------------------------------------------------------------
package utmr_pkg;

	localparam logic [7:0] ReplacementReset = 8'h3F;   // '?'
	localparam logic [7:0] AsciiLast        = 8'h7F;
	localparam logic [7:0] TwoByteLast      = 8'hDF;

	// Continuation bytes still due
	localparam logic [1:0] PendNone = 2'd0;
	localparam logic [1:0] PendOne  = 2'd1;
	localparam logic [1:0] PendTwo  = 2'd2;

	// Stage 1 transaction handed from the decoder to the mapper
	typedef struct packed {
		logic        valid;
		logic [15:0] code_point;
		logic        truncated;
		logic        last;
	} utmr_dec_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] code;
	} utmr_map_t;

	// Reverse MacRoman table for the upper half (0x80..0xFF)
	function automatic utmr_map_t utmr_lookup(input logic [15:0] cp);
		utmr_map_t r;
		r.hit = 1'b1;
		case (cp)
			16'h00C4: r.code = 8'h80;  16'h00C5: r.code = 8'h81;  16'h00C7: r.code = 8'h82;
			16'h00C9: r.code = 8'h83;  16'h00D1: r.code = 8'h84;  16'h00D6: r.code = 8'h85;
			16'h00DC: r.code = 8'h86;  16'h00E1: r.code = 8'h87;
			16'h00E0: r.code = 8'h88;  16'h00E2: r.code = 8'h89;  16'h00E4: r.code = 8'h8A;
			16'h00E3: r.code = 8'h8B;  16'h00E5: r.code = 8'h8C;  16'h00E7: r.code = 8'h8D;
			16'h00E9: r.code = 8'h8E;  16'h00E8: r.code = 8'h8F;
			16'h00EA: r.code = 8'h90;  16'h00EB: r.code = 8'h91;  16'h00ED: r.code = 8'h92;
			16'h00EC: r.code = 8'h93;  16'h00EE: r.code = 8'h94;  16'h00EF: r.code = 8'h95;
			16'h00F1: r.code = 8'h96;  16'h00F3: r.code = 8'h97;
			16'h00F2: r.code = 8'h98;  16'h00F4: r.code = 8'h99;  16'h00F6: r.code = 8'h9A;
			16'h00F5: r.code = 8'h9B;  16'h00FA: r.code = 8'h9C;  16'h00F9: r.code = 8'h9D;
			16'h00FB: r.code = 8'h9E;  16'h00FC: r.code = 8'h9F;
			16'h2020: r.code = 8'hA0;  16'h00B0: r.code = 8'hA1;  16'h00A2: r.code = 8'hA2;
			16'h00A3: r.code = 8'hA3;  16'h00A7: r.code = 8'hA4;  16'h2022: r.code = 8'hA5;
			16'h00B6: r.code = 8'hA6;  16'h00DF: r.code = 8'hA7;
			16'h00AE: r.code = 8'hA8;  16'h00A9: r.code = 8'hA9;  16'h2122: r.code = 8'hAA;
			16'h00B4: r.code = 8'hAB;  16'h00A8: r.code = 8'hAC;  16'h2260: r.code = 8'hAD;
			16'h00C6: r.code = 8'hAE;  16'h00D8: r.code = 8'hAF;
			16'h221E: r.code = 8'hB0;  16'h00B1: r.code = 8'hB1;  16'h2264: r.code = 8'hB2;
			16'h2265: r.code = 8'hB3;  16'h00A5: r.code = 8'hB4;  16'h00B5: r.code = 8'hB5;
			16'h2202: r.code = 8'hB6;  16'h2211: r.code = 8'hB7;
			16'h220F: r.code = 8'hB8;  16'h03C0: r.code = 8'hB9;  16'h222B: r.code = 8'hBA;
			16'h00AA: r.code = 8'hBB;  16'h00BA: r.code = 8'hBC;  16'h03A9: r.code = 8'hBD;
			16'h00E6: r.code = 8'hBE;  16'h00F8: r.code = 8'hBF;
			16'h00BF: r.code = 8'hC0;  16'h00A1: r.code = 8'hC1;  16'h00AC: r.code = 8'hC2;
			16'h221A: r.code = 8'hC3;  16'h0192: r.code = 8'hC4;  16'h2248: r.code = 8'hC5;
			16'h2206: r.code = 8'hC6;  16'h00AB: r.code = 8'hC7;
			16'h00BB: r.code = 8'hC8;  16'h2026: r.code = 8'hC9;  16'h00A0: r.code = 8'hCA;
			16'h00C0: r.code = 8'hCB;  16'h00C3: r.code = 8'hCC;  16'h00D5: r.code = 8'hCD;
			16'h0152: r.code = 8'hCE;  16'h0153: r.code = 8'hCF;
			16'h2013: r.code = 8'hD0;  16'h2014: r.code = 8'hD1;  16'h201C: r.code = 8'hD2;
			16'h201D: r.code = 8'hD3;  16'h2018: r.code = 8'hD4;  16'h2019: r.code = 8'hD5;
			16'h00F7: r.code = 8'hD6;  16'h25CA: r.code = 8'hD7;
			16'h00FF: r.code = 8'hD8;  16'h0178: r.code = 8'hD9;  16'h2044: r.code = 8'hDA;
			16'h20AC: r.code = 8'hDB;  16'h2039: r.code = 8'hDC;  16'h203A: r.code = 8'hDD;
			16'hFB01: r.code = 8'hDE;  16'hFB02: r.code = 8'hDF;
			16'h2021: r.code = 8'hE0;  16'h00B7: r.code = 8'hE1;  16'h201A: r.code = 8'hE2;
			16'h201E: r.code = 8'hE3;  16'h2030: r.code = 8'hE4;  16'h00C2: r.code = 8'hE5;
			16'h00CA: r.code = 8'hE6;  16'h00C1: r.code = 8'hE7;
			16'h00CB: r.code = 8'hE8;  16'h00C8: r.code = 8'hE9;  16'h00CD: r.code = 8'hEA;
			16'h00CE: r.code = 8'hEB;  16'h00CF: r.code = 8'hEC;  16'h00CC: r.code = 8'hED;
			16'h00D3: r.code = 8'hEE;  16'h00D4: r.code = 8'hEF;
			16'hF8FF: r.code = 8'hF0;  16'h00D2: r.code = 8'hF1;  16'h00DA: r.code = 8'hF2;
			16'h00DB: r.code = 8'hF3;  16'h00D9: r.code = 8'hF4;  16'h0131: r.code = 8'hF5;
			16'h02C6: r.code = 8'hF6;  16'h02DC: r.code = 8'hF7;
			16'h00AF: r.code = 8'hF8;  16'h02D8: r.code = 8'hF9;  16'h02D9: r.code = 8'hFA;
			16'h02DA: r.code = 8'hFB;  16'h00B8: r.code = 8'hFC;  16'h02DD: r.code = 8'hFD;
			16'h02DB: r.code = 8'hFE;  16'h02C7: r.code = 8'hFF;
			default: begin
				r.hit  = 1'b0;
				r.code = 8'h00;
			end
		endcase
		return r;
	endfunction

endpackage

// ===== design/utmr_decoder.sv =====
// ----------------------------------------------------------------------------
// utmr_decoder
// Gathers UTF-8 bytes into code points and registers each completed or
// truncated sequence as one stage 1 transaction.
// ----------------------------------------------------------------------------
module utmr_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               advance,
	input  logic [7:0]         in_byte,
	input  logic               end_of_string,
	output utmr_pkg::utmr_dec_t dec_s1
);
	import utmr_pkg::*;

	logic [15:0] cp_q;
	logic [1:0]  pend_q;
	logic [15:0] cp_n;
	logic [1:0]  pend_n;
	logic        emit;
	logic        trunc;
	logic        valid_s1;
	logic [15:0] cp_s1;
	logic        trunc_s1;
	logic        last_s1;

	always_comb begin
		cp_n   = cp_q;
		pend_n = pend_q;
		if (pend_q == PendNone) begin
			if (in_byte inside {[8'h00:AsciiLast]}) begin
				cp_n   = {8'h00, in_byte};
				pend_n = PendNone;
			end else if (in_byte inside {[8'h80:TwoByteLast]}) begin
				cp_n   = {5'b0, in_byte[4:0], 6'b0};
				pend_n = PendOne;
			end else begin
				cp_n   = {in_byte[3:0], 12'b0};
				pend_n = PendTwo;
			end
		end else begin
			if (pend_q == PendTwo)
				cp_n = cp_q | {4'b0, in_byte[5:0], 6'b0};
			else
				cp_n = cp_q | {10'b0, in_byte[5:0]};
			pend_n = pend_q - 2'd1;
		end
		trunc = (pend_n != PendNone) && end_of_string;
		emit  = (pend_n == PendNone) || end_of_string;
	end

	// Sequence state: hold partial bits until the sequence completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_q   <= '0;
			pend_q <= PendNone;
		end else if (accept) begin
			if (emit) begin
				cp_q   <= '0;
				pend_q <= PendNone;
			end else begin
				cp_q   <= cp_n;
				pend_q <= pend_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (advance)
			valid_s1 <= accept && emit;
	end

	always_ff @(posedge clk) begin
		if (advance && accept) begin
			cp_s1    <= cp_n;
			trunc_s1 <= trunc;
			last_s1  <= end_of_string;
		end
	end

	assign dec_s1 = {valid_s1, cp_s1, trunc_s1, last_s1};

endmodule

// ===== design/utmr_mapper.sv =====
// ----------------------------------------------------------------------------
// utmr_mapper
// Maps a code point to MacRoman and holds the result register.
// ----------------------------------------------------------------------------
module utmr_mapper (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  utmr_pkg::utmr_dec_t dec_s1,
	input  logic [7:0]          replacement,
	output logic                valid_s2,
	output logic [7:0]          mac_s2,
	output logic                miss_s2,
	output logic                last_s2
);
	import utmr_pkg::*;

	utmr_map_t look;
	logic [7:0] mac_n;
	logic       miss_n;

	always_comb begin
		look   = utmr_lookup(dec_s1.code_point);
		mac_n  = look.code;
		miss_n = 1'b0;
		if (dec_s1.truncated) begin
			mac_n  = replacement;
			miss_n = 1'b1;
		end else if (dec_s1.code_point <= {8'h00, AsciiLast}) begin
			mac_n = dec_s1.code_point[7:0];
		end else if (!look.hit) begin
			mac_n  = replacement;
			miss_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (advance)
			valid_s2 <= dec_s1.valid;
	end

	always_ff @(posedge clk) begin
		if (advance && dec_s1.valid) begin
			mac_s2  <= mac_n;
			miss_s2 <= miss_n;
			last_s2 <= dec_s1.last;
		end
	end

endmodule

// ===== design/utf8_to_mac_roman_transcoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_mac_roman_transcoder
// Lax UTF-8 decoder that emits one MacRoman byte per decoded sequence.
// ----------------------------------------------------------------------------
// The block takes one UTF-8 byte per clock while in_stall is low and gives
// one MacRoman byte per completed sequence through the stage 1 register and
// then the result register. Leads below 0x80 are single bytes, leads below
// 0xE0 open a two-byte sequence and all others a three-byte sequence;
// following bytes contribute their low six bits without checks. Code points
// up to 0x7F pass through, the rest go through the reverse MacRoman table,
// and a miss gives replacement_byte with unmapped set. A sequence cut short
// by end_of_string yields replacement_byte, unmapped and last_result. The
// unstalled rate is one byte per cycle: the sequence state updates on each
// accepted byte, and the table lookup has its own stage between the decode
// and result registers. replacement_byte (reset '?') is written through the
// cfg channel, which is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module utf8_to_mac_roman_transcoder (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_string,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] mac_byte,
	output logic       unmapped,
	output logic       last_result,
	// configuration channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] replacement_byte
);
	import utmr_pkg::*;

	logic      repl_en;
	logic [7:0] repl_q;
	logic      adv_s1;
	logic      adv_s2;
	logic      accept;
	utmr_dec_t dec_s1;

	// Advance the result register whenever it is empty or being drained;
	// advance stage 1 whenever it is empty or can move forward.
	assign adv_s2   = !out_valid || !out_stall;
	assign adv_s1   = !dec_s1.valid || adv_s2;
	assign in_stall = !adv_s1;
	assign accept   = in_valid && adv_s1;

	// Configuration register: take every write transaction immediately
	assign cfg_ready = 1'b1;
	assign repl_en   = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			repl_q <= ReplacementReset;
		else if (repl_en)
			repl_q <= replacement_byte;
	end

	// Sequence assembly and stage 1 register
	utmr_decoder u_decoder (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.advance       (adv_s1),
		.in_byte       (in_byte),
		.end_of_string (end_of_string),
		.dec_s1        (dec_s1)
	);

	// Table lookup and result register
	utmr_mapper u_mapper (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (adv_s2),
		.dec_s1      (dec_s1),
		.replacement (repl_q),
		.valid_s2    (out_valid),
		.mac_s2      (mac_byte),
		.miss_s2     (unmapped),
		.last_s2     (last_result)
	);

endmodule
